@@ design/ecbs_pkg.sv @@
`timescale 1ns / 1ps

package ecbs_pkg;

  localparam int unsigned MaxCodeDefault = 99;

  localparam int unsigned MsWidth   = 11;
  localparam int unsigned CodeWidth = 8;
  localparam int unsigned TensWidth = 5;
  localparam int unsigned UnitWidth = 4;
  localparam int unsigned IdxWidth  = 5;
  localparam int unsigned HpWidth   = 8;

  localparam logic [MsWidth-1:0] MsIntro     = 11'd100;
  localparam logic [MsWidth-1:0] MsIntroDark = 11'd1100;
  localparam logic [MsWidth-1:0] MsLong      = 11'd2000;
  localparam logic [MsWidth-1:0] MsTens      = 11'd1000;
  localparam logic [MsWidth-1:0] MsTensGap   = 11'd350;
  localparam logic [MsWidth-1:0] MsUnits     = 11'd200;

  localparam logic [HpWidth-1:0] HpSpeedStart = 8'd3;
  localparam logic [HpWidth-1:0] HpSlowStart  = 8'd180;
  localparam logic [HpWidth-1:0] HpStepMax    = 8'd35;

  localparam logic [IdxWidth-1:0] SpeedBlinks = 5'd15;
  localparam logic [IdxWidth-1:0] SlowBlinks  = 5'd20;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_INTRO    = 3'd1,
    PH_SPEEDUP  = 3'd2,
    PH_SLOWDOWN = 3'd3,
    PH_GAP      = 3'd4,
    PH_TENS     = 3'd5,
    PH_UNITS    = 3'd6,
    PH_TAIL     = 3'd7
  } phase_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] code;
  } req_t;

  typedef struct packed {
    logic       led_on;
    logic [2:0] phase_now;
  } rsp_t;

  // Division by ten of an 8-bit value through a reciprocal multiply.
  function automatic logic [TensWidth-1:0] div10(input logic [CodeWidth-1:0] v);
    logic [18:0] prod;
    prod = {11'd0, v} * 19'd205;
    return prod[15:11];
  endfunction

  // Division by five of an 8-bit value through a reciprocal multiply.
  function automatic logic [HpWidth-1:0] div5(input logic [HpWidth-1:0] v);
    logic [18:0] prod;
    prod = {11'd0, v} * 19'd205;
    return {2'd0, prod[15:10]};
  endfunction

endpackage

@@ design/exit_code_blink_sequencer.sv @@
`timescale 1ns / 1ps

// Exit-code blink sequencer, stepped by one request per millisecond.
// Requests arrive on req/req_valid/req_stall: cmd = tick advances the LED
// pattern by one millisecond, cmd = start latches a code (clamped to
// MAX_CODE, negative codes show as MAX_CODE) and restarts the pattern.
// Every request yields exactly one response on rsp/rsp_valid/rsp_stall,
// carrying the LED level and the phase for that millisecond.
// The response is registered: it is valid in the cycle after its request
// is accepted. Throughput is one request per cycle while rsp_stall is low;
// the single state update and the response register are the only stages.
// While the receiver holds rsp_stall high, the response stays in the
// output register and req_stall rises, so no request is taken until the
// waiting response has been taken.
// After reset the block is idle: ticks return a dark LED and phase zero
// until a start request arrives. The pattern then repeats indefinitely.
module exit_code_blink_sequencer
  import ecbs_pkg::*;
#(
  parameter int unsigned MAX_CODE = MaxCodeDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [CodeWidth-1:0] MaxCode = CodeWidth'(MAX_CODE);

  logic                 running, running_next;
  phase_t               phase, phase_next;
  logic [MsWidth-1:0]   ms_left, ms_left_next;
  logic                 lit_half, lit_half_next;
  logic [IdxWidth-1:0]  blink_index, blink_index_next;
  logic [HpWidth-1:0]   half_period, half_period_next;
  logic [TensWidth-1:0] tens, tens_next;
  logic [UnitWidth-1:0] units, units_next;
  rsp_t                 rsp_next;
  logic                 accept;

  logic [CodeWidth-1:0] clamped;
  logic [TensWidth-1:0] clamped_tens;
  logic [7:0]           tens_times10;
  logic [MsWidth-1:0]   ms_dec;
  logic [IdxWidth-1:0]  idx_inc;
  logic [HpWidth-1:0]   step_up, hp_up, step_dn, hp_dn, hp_sub;
  phase_t               u_phase, t_phase;
  logic                 u_lit, t_lit;
  logic [MsWidth-1:0]   u_ms, t_ms;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign clamped = (req.code[15] || ($unsigned(req.code) > {8'd0, MaxCode}))
                   ? MaxCode : req.code[CodeWidth-1:0];
  assign clamped_tens = div10(clamped);
  assign tens_times10 = {3'd0, clamped_tens} * 8'd10;

  assign ms_dec  = (ms_left == '0) ? '0 : ms_left - 1'b1;
  assign idx_inc = blink_index + 1'b1;

  always_comb begin
    step_up = div5(half_period);
    if (step_up > HpStepMax) begin
      step_up = HpStepMax;
    end
    if (step_up == '0) begin
      step_up = 8'd1;
    end
    hp_up = half_period + step_up;
    step_dn = {2'd0, half_period[HpWidth-1:2]};
    if (step_dn > HpStepMax) begin
      step_dn = HpStepMax;
    end
    hp_sub = half_period - step_dn;
    hp_dn  = (hp_sub == '0) ? 8'd1 : hp_sub;
  end

  always_comb begin
    if (units == '0) begin
      u_phase = PH_TAIL;
      u_lit   = 1'b0;
      u_ms    = MsLong;
    end else begin
      u_phase = PH_UNITS;
      u_lit   = 1'b1;
      u_ms    = MsUnits;
    end
    if (tens == '0) begin
      t_phase = u_phase;
      t_lit   = u_lit;
      t_ms    = u_ms;
    end else begin
      t_phase = PH_TENS;
      t_lit   = 1'b1;
      t_ms    = MsTens;
    end
  end

  always_comb begin
    running_next     = running;
    phase_next       = phase;
    ms_left_next     = ms_left;
    lit_half_next    = lit_half;
    blink_index_next = blink_index;
    half_period_next = half_period;
    tens_next        = tens;
    units_next       = units;
    if (req.cmd == CMD_START) begin
      tens_next        = clamped_tens;
      units_next       = UnitWidth'(clamped - tens_times10);
      running_next     = 1'b1;
      phase_next       = PH_INTRO;
      blink_index_next = '0;
      half_period_next = '0;
      lit_half_next    = 1'b0;
      ms_left_next     = MsIntro;
    end else if (running) begin
      ms_left_next = ms_dec;
      if (ms_dec == '0) begin
        unique case (phase)
          PH_INTRO: begin
            blink_index_next = idx_inc;
            if (idx_inc == 5'd1) begin
              lit_half_next = 1'b1;
              ms_left_next  = MsIntro;
            end else if (idx_inc == 5'd2) begin
              lit_half_next = 1'b0;
              ms_left_next  = MsIntroDark;
            end else begin
              phase_next       = PH_SPEEDUP;
              blink_index_next = '0;
              half_period_next = HpSpeedStart;
              lit_half_next    = 1'b1;
              ms_left_next     = {3'd0, HpSpeedStart};
            end
          end
          PH_SPEEDUP: begin
            if (lit_half) begin
              lit_half_next = 1'b0;
              ms_left_next  = {3'd0, half_period};
            end else if (idx_inc < SpeedBlinks) begin
              blink_index_next = idx_inc;
              half_period_next = hp_up;
              lit_half_next    = 1'b1;
              ms_left_next     = {3'd0, hp_up};
            end else begin
              phase_next       = PH_SLOWDOWN;
              blink_index_next = '0;
              half_period_next = HpSlowStart;
              lit_half_next    = 1'b1;
              ms_left_next     = {3'd0, HpSlowStart};
            end
          end
          PH_SLOWDOWN: begin
            if (lit_half) begin
              lit_half_next = 1'b0;
              ms_left_next  = {3'd0, half_period};
            end else if (idx_inc < SlowBlinks) begin
              blink_index_next = idx_inc;
              half_period_next = hp_dn;
              lit_half_next    = 1'b1;
              ms_left_next     = {3'd0, hp_dn};
            end else begin
              phase_next       = PH_GAP;
              blink_index_next = '0;
              half_period_next = hp_dn;
              lit_half_next    = 1'b0;
              ms_left_next     = MsLong;
            end
          end
          PH_GAP: begin
            phase_next       = t_phase;
            blink_index_next = '0;
            lit_half_next    = t_lit;
            ms_left_next     = t_ms;
          end
          PH_TENS: begin
            if (lit_half) begin
              lit_half_next = 1'b0;
              ms_left_next  = MsTens;
            end else if (idx_inc < tens) begin
              blink_index_next = idx_inc;
              lit_half_next    = 1'b1;
              ms_left_next     = MsTens;
            end else if (idx_inc == tens) begin
              blink_index_next = idx_inc;
              lit_half_next    = 1'b0;
              ms_left_next     = MsTensGap;
            end else begin
              phase_next       = u_phase;
              blink_index_next = '0;
              lit_half_next    = u_lit;
              ms_left_next     = u_ms;
            end
          end
          PH_UNITS: begin
            if (lit_half) begin
              lit_half_next = 1'b0;
              ms_left_next  = MsUnits;
            end else if (idx_inc < {1'b0, units}) begin
              blink_index_next = idx_inc;
              lit_half_next    = 1'b1;
              ms_left_next     = MsUnits;
            end else begin
              phase_next       = PH_TAIL;
              blink_index_next = '0;
              lit_half_next    = 1'b0;
              ms_left_next     = MsLong;
            end
          end
          PH_IDLE, PH_TAIL: begin
            phase_next       = PH_SPEEDUP;
            blink_index_next = '0;
            half_period_next = HpSpeedStart;
            lit_half_next    = 1'b1;
            ms_left_next     = {3'd0, HpSpeedStart};
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (req.cmd == CMD_START) begin
      rsp_next.led_on    = 1'b0;
      rsp_next.phase_now = PH_INTRO;
    end else if (running) begin
      rsp_next.led_on    = lit_half;
      rsp_next.phase_now = phase;
    end else begin
      rsp_next.led_on    = 1'b0;
      rsp_next.phase_now = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      phase       <= PH_IDLE;
      ms_left     <= '0;
      lit_half    <= 1'b0;
      blink_index <= '0;
      half_period <= '0;
      tens        <= '0;
      units       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (accept) begin
        running     <= running_next;
        phase       <= phase_next;
        ms_left     <= ms_left_next;
        lit_half    <= lit_half_next;
        blink_index <= blink_index_next;
        half_period <= half_period_next;
        tens        <= tens_next;
        units       <= units_next;
      end
      rsp_valid <= accept || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule
